// ===== hw/rtl/aat_pkg.sv =====
`timescale 1ns / 1ps

package aat_pkg;

  // Default coordinate width, Q(W-16).16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int COEF_BITS       = 20;
  localparam int ROW_WIDTH       = 3 * COEF_BITS;

  // Configuration port
  localparam int CFG_WIDTH       = ROW_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW0    = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW1    = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW2    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHIFT_X = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHIFT_Y = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHIFT_Z = 3'd5;

  // Identity matrix rows after reset (1.0 in Q4.16 on the diagonal)
  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = ROW_WIDTH'(1) << FRAC_BITS;
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = ROW_WIDTH'(1) << (FRAC_BITS + COEF_BITS);
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = ROW_WIDTH'(1) << (FRAC_BITS + 2 * COEF_BITS);

  typedef logic signed [COEF_BITS-1:0] coef_t;

endpackage

// ===== hw/rtl/aabb_affine_transform.sv =====
`timescale 1ns / 1ps
// Pipeline: five register stages (corner, product, min/max, sum and
//   output).
// Throughput: one box per cycle while out_stall is low; each stage advances
//   when it is empty or the next stage takes its item, so bubbles close up under out_stall.
// Reset (synchronous): all stage valid bits clear, matrix returns to
//   identity and translation to zero.

module aabb_affine_transform
  import aat_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_WIDTH-1:0]          cfg_data,
  // Input box
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic        [COORD_WIDTH-2:0] half_x,
  input  logic        [COORD_WIDTH-2:0] half_y,
  input  logic        [COORD_WIDTH-2:0] half_z,
  // Transformed box
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] new_center_x,
  output logic signed [COORD_WIDTH-1:0] new_center_y,
  output logic signed [COORD_WIDTH-1:0] new_center_z,
  output logic        [COORD_WIDTH-2:0] new_half_x,
  output logic        [COORD_WIDTH-2:0] new_half_y,
  output logic        [COORD_WIDTH-2:0] new_half_z
);

  localparam int CW = COORD_WIDTH;
  localparam int PW = CW + 5;
  localparam int SW = CW + 7;

  // Configuration registers
  logic        [ROW_WIDTH-1:0] linear_row0;
  logic        [ROW_WIDTH-1:0] linear_row1;
  logic        [ROW_WIDTH-1:0] linear_row2;
  logic signed [CW-1:0]        shift_x;
  logic signed [CW-1:0]        shift_y;
  logic signed [CW-1:0]        shift_z;

  coef_t                coef   [3][3];
  logic signed [CW-1:0] shift  [3];
  logic signed [CW-1:0] center [3];
  logic        [CW-2:0] half   [3];

  // Stage handshakes
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r5;
  logic r5_stage;

  // Stage payloads
  logic signed [CW:0]   lo   [3];
  logic signed [CW:0]   hi   [3];
  logic signed [PW-1:0] plo  [3][3];
  logic signed [PW-1:0] phi  [3][3];
  logic signed [PW-1:0] pmin [3][3];
  logic signed [PW-1:0] pmax [3][3];
  logic signed [SW-1:0] mn   [3];
  logic signed [SW-1:0] mx   [3];
  logic signed [CW-1:0] ocenter [3];
  logic        [CW-2:0] ohalf   [3];

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_row0 <= ROW0_RESET;
      linear_row1 <= ROW1_RESET;
      linear_row2 <= ROW2_RESET;
      shift_x     <= '0;
      shift_y     <= '0;
      shift_z     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW0:    linear_row0 <= cfg_data[ROW_WIDTH-1:0];
        CFG_ROW1:    linear_row1 <= cfg_data[ROW_WIDTH-1:0];
        CFG_ROW2:    linear_row2 <= cfg_data[ROW_WIDTH-1:0];
        CFG_SHIFT_X: shift_x     <= cfg_data[CW-1:0];
        CFG_SHIFT_Y: shift_y     <= cfg_data[CW-1:0];
        CFG_SHIFT_Z: shift_z     <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the matrix coefficients
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coef[0][j] = linear_row0[j*COEF_BITS +: COEF_BITS];
      coef[1][j] = linear_row1[j*COEF_BITS +: COEF_BITS];
      coef[2][j] = linear_row2[j*COEF_BITS +: COEF_BITS];
    end
  end

  assign shift[0]  = shift_x;
  assign shift[1]  = shift_y;
  assign shift[2]  = shift_z;
  assign center[0] = center_x;
  assign center[1] = center_y;
  assign center[2] = center_z;
  assign half[0]   = half_x;
  assign half[1]   = half_y;
  assign half[2]   = half_z;

  assign in_stall = !r1;
  assign r5       = !out_stall;

  aat_corner_stage #(.CW(CW)) u_corner (
    .clk     (clk),
    .rst     (rst),
    .valid_i (in_valid),
    .ready_o (r1),
    .ready_i (r2),
    .valid_o (v1),
    .center  (center),
    .half    (half),
    .lo      (lo),
    .hi      (hi)
  );

  aat_product_stage #(.CW(CW)) u_product (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v1),
    .ready_o (r2),
    .ready_i (r3),
    .valid_o (v2),
    .lo      (lo),
    .hi      (hi),
    .coef    (coef),
    .plo     (plo),
    .phi     (phi)
  );

  aat_minmax_stage #(.CW(CW)) u_minmax (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v2),
    .ready_o (r3),
    .ready_i (r4),
    .valid_o (v3),
    .plo     (plo),
    .phi     (phi),
    .pmin    (pmin),
    .pmax    (pmax)
  );

  aat_sum_stage #(.CW(CW)) u_sum (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v3),
    .ready_o (r4),
    .ready_i (r5_stage),
    .valid_o (v4),
    .pmin    (pmin),
    .pmax    (pmax),
    .shift   (shift),
    .mn      (mn),
    .mx      (mx)
  );

  aat_output_stage #(.CW(CW)) u_output (
    .clk     (clk),
    .rst     (rst),
    .valid_i (v4),
    .ready_o (r5_stage),
    .ready_i (r5),
    .valid_o (out_valid),
    .mn      (mn),
    .mx      (mx),
    .center  (ocenter),
    .half    (ohalf)
  );

  assign new_center_x = ocenter[0];
  assign new_center_y = ocenter[1];
  assign new_center_z = ocenter[2];
  assign new_half_x   = ohalf[0];
  assign new_half_y   = ohalf[1];
  assign new_half_z   = ohalf[2];

  // An accepted item always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v1)
    else $error("accepted item missing from corner stage");

  // Input stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid))
    else $error("input stalled with a free stage");

  // A new result comes only from a filled sum stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("result appeared without a source item");

endmodule

// ===== hw/rtl/aat_corner_stage.sv =====
`timescale 1ns / 1ps

module aat_corner_stage
  import aat_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 ready_i,
  output logic                 valid_o,
  input  logic signed [CW-1:0] center [3],
  input  logic        [CW-2:0] half   [3],
  output logic signed [CW:0]   lo     [3],
  output logic signed [CW:0]   hi     [3]
);

  logic signed [CW:0] lo_next [3];
  logic signed [CW:0] hi_next [3];

  assign ready_o = !valid_o || ready_i;

  // Corner extremes per axis, one bit wider than a coordinate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_next[a] = {center[a][CW-1], center[a]} - {2'b00, half[a]};
      hi_next[a] = {center[a][CW-1], center[a]} + {2'b00, half[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

endmodule

// ===== hw/rtl/aat_product_stage.sv =====
`timescale 1ns / 1ps

module aat_product_stage
  import aat_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  localparam int PW = CW + 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 ready_i,
  output logic                 valid_o,
  input  logic signed [CW:0]   lo   [3],
  input  logic signed [CW:0]   hi   [3],
  input  coef_t                coef [3][3],
  output logic signed [PW-1:0] plo  [3][3],
  output logic signed [PW-1:0] phi  [3][3]
);

  logic signed [CW+COEF_BITS:0] mlo [3][3];
  logic signed [CW+COEF_BITS:0] mhi [3][3];

  assign ready_o = !valid_o || ready_i;

  // 18 products: both corner extremes of each axis times each coefficient
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        mlo[a][j] = lo[a] * coef[a][j];
        mhi[a][j] = hi[a] * coef[a][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  // Drop the fraction bits: floor toward minus infinity
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          plo[a][j] <= mlo[a][j][CW+COEF_BITS:FRAC_BITS];
          phi[a][j] <= mhi[a][j][CW+COEF_BITS:FRAC_BITS];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/aat_minmax_stage.sv =====
`timescale 1ns / 1ps

module aat_minmax_stage
  import aat_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  localparam int PW = CW + 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 ready_i,
  output logic                 valid_o,
  input  logic signed [PW-1:0] plo  [3][3],
  input  logic signed [PW-1:0] phi  [3][3],
  output logic signed [PW-1:0] pmin [3][3],
  output logic signed [PW-1:0] pmax [3][3]
);

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  // Each axis picks its side independently, so the corner min/max over
  // eight corners is the sum of per-term min/max
  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          if (plo[a][j] < phi[a][j]) begin
            pmin[a][j] <= plo[a][j];
            pmax[a][j] <= phi[a][j];
          end else begin
            pmin[a][j] <= phi[a][j];
            pmax[a][j] <= plo[a][j];
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/aat_sum_stage.sv =====
`timescale 1ns / 1ps

module aat_sum_stage
  import aat_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  localparam int PW = CW + 5,
  localparam int SW = CW + 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 ready_i,
  output logic                 valid_o,
  input  logic signed [PW-1:0] pmin  [3][3],
  input  logic signed [PW-1:0] pmax  [3][3],
  input  logic signed [CW-1:0] shift [3],
  output logic signed [SW-1:0] mn    [3],
  output logic signed [SW-1:0] mx    [3]
);

  logic signed [SW-1:0] mn_next [3];
  logic signed [SW-1:0] mx_next [3];

  assign ready_o = !valid_o || ready_i;

  // Per output axis: translation plus the three row terms
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mn_next[j] = {{(SW-CW){shift[j][CW-1]}}, shift[j]};
      mx_next[j] = {{(SW-CW){shift[j][CW-1]}}, shift[j]};
      for (int a = 0; a < 3; a++) begin
        mn_next[j] = mn_next[j] + {{(SW-PW){pmin[a][j][PW-1]}}, pmin[a][j]};
        mx_next[j] = mx_next[j] + {{(SW-PW){pmax[a][j][PW-1]}}, pmax[a][j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      mn <= mn_next;
      mx <= mx_next;
    end
  end

endmodule

// ===== hw/rtl/aat_output_stage.sv =====
`timescale 1ns / 1ps

module aat_output_stage
  import aat_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF,
  localparam int SW = CW + 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 ready_i,
  output logic                 valid_o,
  input  logic signed [SW-1:0] mn     [3],
  input  logic signed [SW-1:0] mx     [3],
  output logic signed [CW-1:0] center [3],
  output logic        [CW-2:0] half   [3]
);

  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [SW:0]   csum [3];
  logic signed [SW:0]   hdif [3];
  logic signed [SW-1:0] c    [3];
  logic signed [SW-1:0] h    [3];
  logic signed [CW-1:0] center_next [3];
  logic        [CW-2:0] half_next   [3];

  assign ready_o = !valid_o || ready_i;

  // Halve with floor, then saturate to the coordinate range
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      csum[j] = {mn[j][SW-1], mn[j]} + {mx[j][SW-1], mx[j]};
      hdif[j] = {mx[j][SW-1], mx[j]} - {mn[j][SW-1], mn[j]};
      c[j]    = csum[j][SW:1];
      h[j]    = hdif[j][SW:1];
      if (c[j] > CMAX) begin
        center_next[j] = CMAX[CW-1:0];
      end else if (c[j] < CMIN) begin
        center_next[j] = CMIN[CW-1:0];
      end else begin
        center_next[j] = c[j][CW-1:0];
      end
      if (h[j] > CMAX) begin
        half_next[j] = CMAX[CW-2:0];
      end else begin
        half_next[j] = h[j][CW-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      center <= center_next;
      half   <= half_next;
    end
  end

endmodule
